>>> sv/pts_pkg.sv
// pts_pkg: shared widths, command and register codes, reset values
// for the pan/tilt servo stepper. No dependencies.
package pts_pkg;

	// fixed field and register widths
	localparam int LIM_W       = 10;
	localparam int INC_W       = 8;
	localparam int LEN_W       = 7;
	localparam int FIELD_POS_W = 10;
	localparam int PIDX_W      = 6;
	localparam int DIR_W       = 3;
	localparam int RPT_W       = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 10;

	// stream payload layout
	localparam int S_FIELDS_W = DIR_W + PIDX_W + 2 * FIELD_POS_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int S_PAD_W    = S_TDATA_W - S_FIELDS_W;
	localparam int M_FIELDS_W = 2 * FIELD_POS_W + RPT_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	// parameter defaults
	localparam int DEFAULT_ROUTE_DEPTH = 64;
	localparam int DEFAULT_POS_WIDTH   = 10;

	// longest route a length register can ask for
	localparam int LEN_MAX = (1 << LEN_W) - 1;

	// direction commands
	localparam logic [DIR_W-1:0] DIR_NONE   = 3'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN   = 3'd1;
	localparam logic [DIR_W-1:0] DIR_UP     = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd3;
	localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd4;
	localparam logic [DIR_W-1:0] DIR_FOLLOW = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_INCREMENT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_INCREMENT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE_LENGTH = 3'd4;

	// register reset values
	localparam logic [LIM_W-1:0] X_LIMIT_RST      = 10'd180;
	localparam logic [LIM_W-1:0] Y_LIMIT_RST      = 10'd180;
	localparam logic [INC_W-1:0] X_INCREMENT_RST  = 8'd1;
	localparam logic [INC_W-1:0] Y_INCREMENT_RST  = 8'd1;
	localparam logic [LEN_W-1:0] ROUTE_LENGTH_RST = 7'd1;

	typedef struct packed {
		logic             action;
		logic [DIR_W-1:0] direction;
	} cmd_t;

endpackage

>>> sv/pts_ram.sv
// pts_ram: generic single write port, single read port RAM with
// registered read data (old data on a same-address write). No dependencies.
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/pts_axis.sv
// pts_axis: one axis step toward its target, clamped so it lands on
// the target instead of overshooting. Depends on pts_pkg.
module pts_axis #(
	parameter int PW = pts_pkg::DEFAULT_POS_WIDTH
) (
	input  logic [PW-1:0]               now,
	input  logic [PW-1:0]               target,
	input  logic [pts_pkg::INC_W-1:0]   inc,
	output logic [PW-1:0]               nxt
);

	logic [PW-1:0] step;
	logic [PW-1:0] dist_up;
	logic [PW-1:0] dist_dn;

	always_comb begin
		// zero increment moves by one
		step    = (inc == '0) ? PW'(1) : PW'(inc);
		dist_up = target - now;
		dist_dn = now - target;
		if (now < target) begin
			nxt = (dist_up <= step) ? target : now + step;
		end else if (now > target) begin
			nxt = (dist_dn <= step) ? target : now - step;
		end else begin
			nxt = now;
		end
	end

endmodule

>>> sv/pts_route.sv
// pts_route: route point selection, index folded into the route length
// and advanced with wrap when both axes stand on target. Depends on pts_pkg.
module pts_route #(
	parameter int IW = 6
) (
	input  logic [IW-1:0]             ridx,
	input  logic [pts_pkg::LEN_W-1:0] len,
	input  logic                      at_target,
	output logic [IW-1:0]             sel
);

	localparam int CW = (IW + 1 > pts_pkg::LEN_W) ? IW + 1 : pts_pkg::LEN_W;

	logic [CW-1:0] ridx_w;
	logic [CW-1:0] len_w;
	logic [CW-1:0] base_w;
	logic [CW-1:0] inc_w;
	logic [CW-1:0] sel_w;

	always_comb begin
		ridx_w = CW'(ridx);
		len_w  = CW'(len);
		// stale index after a length change starts over
		base_w = (ridx_w >= len_w) ? '0 : ridx_w;
		inc_w  = base_w + CW'(1);
		if (at_target) begin
			sel_w = (inc_w >= len_w) ? '0 : inc_w;
		end else begin
			sel_w = base_w;
		end
		sel = sel_w[IW-1:0];
	end

endmodule

>>> sv/pts_step.sv
// pts_step: next state of the servo for one item (targets, motion,
// route index, armed flag). Depends on pts_pkg and pts_axis.
module pts_step #(
	parameter int PW = pts_pkg::DEFAULT_POS_WIDTH,
	parameter int IW = 6
) (
	input  pts_pkg::cmd_t             cmd,
	input  logic [PW-1:0]             x_now,
	input  logic [PW-1:0]             y_now,
	input  logic [PW-1:0]             x_tgt,
	input  logic [PW-1:0]             y_tgt,
	input  logic [IW-1:0]             ridx,
	input  logic                      armed,
	input  logic [pts_pkg::LIM_W-1:0] x_limit,
	input  logic [pts_pkg::LIM_W-1:0] y_limit,
	input  logic [pts_pkg::INC_W-1:0] x_inc,
	input  logic [pts_pkg::INC_W-1:0] y_inc,
	input  logic [IW-1:0]             route_sel,
	input  logic [PW-1:0]             tbl_x,
	input  logic [PW-1:0]             tbl_y,
	output logic [PW-1:0]             x_now_n,
	output logic [PW-1:0]             y_now_n,
	output logic [PW-1:0]             x_tgt_n,
	output logic [PW-1:0]             y_tgt_n,
	output logic [IW-1:0]             ridx_n,
	output logic                      armed_n
);

	logic          moving;
	logic [PW-1:0] x_move;
	logic [PW-1:0] y_move;

	always_comb begin
		x_tgt_n = x_tgt;
		y_tgt_n = y_tgt;
		ridx_n  = ridx;
		armed_n = armed;
		moving  = 1'b1;
		if (cmd.action) begin
			// route load: no motion, route must be re-armed
			armed_n = 1'b0;
			moving  = 1'b0;
		end else begin
			unique case (cmd.direction)
				pts_pkg::DIR_NONE: begin
					x_tgt_n = x_now;
					y_tgt_n = y_now;
				end
				pts_pkg::DIR_DOWN: begin
					x_tgt_n = x_now;
					y_tgt_n = PW'(y_limit);
				end
				pts_pkg::DIR_UP: begin
					x_tgt_n = x_now;
					y_tgt_n = '0;
				end
				pts_pkg::DIR_RIGHT: begin
					x_tgt_n = '0;
					y_tgt_n = y_now;
				end
				pts_pkg::DIR_LEFT: begin
					x_tgt_n = PW'(x_limit);
					y_tgt_n = y_now;
				end
				pts_pkg::DIR_FOLLOW: begin
					if (!armed) begin
						armed_n = 1'b1;
						ridx_n  = '0;
					end else begin
						ridx_n  = route_sel;
						x_tgt_n = tbl_x;
						y_tgt_n = tbl_y;
					end
				end
				default: begin
				end
			endcase
		end
	end

	pts_axis #(.PW(PW)) u_axis_x (
		.now    (x_now),
		.target (x_tgt_n),
		.inc    (x_inc),
		.nxt    (x_move)
	);

	pts_axis #(.PW(PW)) u_axis_y (
		.now    (y_now),
		.target (y_tgt_n),
		.inc    (y_inc),
		.nxt    (y_move)
	);

	assign x_now_n = moving ? x_move : x_now;
	assign y_now_n = moving ? y_move : y_now;

endmodule

>>> sv/pan_tilt_servo_stepper_top.sv
// pan_tilt_servo_stepper_top: two-axis servo position generator with route
// table. Depends on pts_pkg, pts_ram, pts_route, pts_step, pts_axis.
// Path: an accepted transaction passes the input register, then the result
// register, on its way to the master side.
// Throughput: one item per clock while m_axis_tready holds; the route
// table is read ahead from the next route index, so a follow tick never
// waits on the RAM. s_axis_tready is low in a clock with a configuration
// write. Reset: positions, targets, route index, armed flag and registers
// go to their reset values at once; the route table is not cleared.
module pan_tilt_servo_stepper_top #(
	parameter int ROUTE_DEPTH = pts_pkg::DEFAULT_ROUTE_DEPTH,
	parameter int POS_WIDTH   = pts_pkg::DEFAULT_POS_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// stream in
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// direction[2:0], point_index[8:3], point_x[18:9], point_y[28:19], zero pad
	input  logic [pts_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// action
	input  logic                              s_axis_tuser,
	// stream out
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// x_position[9:0], y_position[19:10], route_point[25:20], zero pad
	output logic [pts_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// configuration writes
	input  logic                              wr_en,
	input  logic [pts_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0]    wr_data
);

	localparam int MAXLEN = (ROUTE_DEPTH < pts_pkg::LEN_MAX) ? ROUTE_DEPTH : pts_pkg::LEN_MAX;
	localparam int IW     = $clog2(MAXLEN);
	localparam int AW     = $clog2(ROUTE_DEPTH);
	localparam int PW     = POS_WIDTH;

	// configuration registers
	logic [pts_pkg::LIM_W-1:0] x_limit_q;
	logic [pts_pkg::LIM_W-1:0] y_limit_q;
	logic [pts_pkg::INC_W-1:0] x_inc_q;
	logic [pts_pkg::INC_W-1:0] y_inc_q;
	logic [pts_pkg::LEN_W-1:0] route_len_q;
	logic [pts_pkg::LEN_W-1:0] len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q   <= pts_pkg::X_LIMIT_RST;
			y_limit_q   <= pts_pkg::Y_LIMIT_RST;
			x_inc_q     <= pts_pkg::X_INCREMENT_RST;
			y_inc_q     <= pts_pkg::Y_INCREMENT_RST;
			route_len_q <= pts_pkg::ROUTE_LENGTH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				pts_pkg::REG_X_LIMIT:      x_limit_q   <= wr_data[pts_pkg::LIM_W-1:0];
				pts_pkg::REG_Y_LIMIT:      y_limit_q   <= wr_data[pts_pkg::LIM_W-1:0];
				pts_pkg::REG_X_INCREMENT:  x_inc_q     <= wr_data[pts_pkg::INC_W-1:0];
				pts_pkg::REG_Y_INCREMENT:  y_inc_q     <= wr_data[pts_pkg::INC_W-1:0];
				pts_pkg::REG_ROUTE_LENGTH: route_len_q <= wr_data[pts_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// zero length acts as one; length is capped at min(table depth, LEN_MAX)
	always_comb begin
		if (route_len_q == '0) begin
			len_eff = pts_pkg::LEN_W'(1);
		end else if (32'(route_len_q) > MAXLEN) begin
			len_eff = pts_pkg::LEN_W'(MAXLEN);
		end else begin
			len_eff = route_len_q;
		end
	end

	// input register
	logic                            valid_s1;
	pts_pkg::cmd_t                   cmd_s1;
	logic [pts_pkg::PIDX_W-1:0]      pidx_s1;
	logic [pts_pkg::FIELD_POS_W-1:0] px_s1;
	logic [pts_pkg::FIELD_POS_W-1:0] py_s1;
	logic                            m_valid_q;
	logic                            adv;
	logic                            s_acc;

	assign adv           = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = (!valid_s1 || adv) && !wr_en;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_s1.action    <= s_axis_tuser;
			cmd_s1.direction <= s_axis_tdata[2:0];
			pidx_s1          <= s_axis_tdata[8:3];
			px_s1            <= s_axis_tdata[18:9];
			py_s1            <= s_axis_tdata[28:19];
		end
	end

	// servo state
	logic [PW-1:0] x_now_q;
	logic [PW-1:0] y_now_q;
	logic [PW-1:0] x_tgt_q;
	logic [PW-1:0] y_tgt_q;
	logic [IW-1:0] ridx_q;
	logic          armed_q;
	logic [IW-1:0] ra_q;

	logic [PW-1:0] x_now_n;
	logic [PW-1:0] y_now_n;
	logic [PW-1:0] x_tgt_n;
	logic [PW-1:0] y_tgt_n;
	logic [IW-1:0] ridx_n;
	logic          armed_n;

	// route table read data, with same-clock write bypass
	logic [2*PW-1:0] ram_rdata;
	logic [2*PW-1:0] ram_wdata;
	logic [2*PW-1:0] byp_data_q;
	logic            byp_hit_q;
	logic [2*PW-1:0] tbl_data;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [AW-1:0]   ram_raddr;

	assign tbl_data = byp_hit_q ? byp_data_q : ram_rdata;

	pts_step #(.PW(PW), .IW(IW)) u_step (
		.cmd       (cmd_s1),
		.x_now     (x_now_q),
		.y_now     (y_now_q),
		.x_tgt     (x_tgt_q),
		.y_tgt     (y_tgt_q),
		.ridx      (ridx_q),
		.armed     (armed_q),
		.x_limit   (x_limit_q),
		.y_limit   (y_limit_q),
		.x_inc     (x_inc_q),
		.y_inc     (y_inc_q),
		.route_sel (ra_q),
		.tbl_x     (tbl_data[PW-1:0]),
		.tbl_y     (tbl_data[2*PW-1:PW]),
		.x_now_n   (x_now_n),
		.y_now_n   (y_now_n),
		.x_tgt_n   (x_tgt_n),
		.y_tgt_n   (y_tgt_n),
		.ridx_n    (ridx_n),
		.armed_n   (armed_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_now_q <= '0;
			y_now_q <= '0;
			x_tgt_q <= '0;
			y_tgt_q <= '0;
			ridx_q  <= '0;
			armed_q <= 1'b0;
		end else if (adv) begin
			x_now_q <= x_now_n;
			y_now_q <= y_now_n;
			x_tgt_q <= x_tgt_n;
			y_tgt_q <= y_tgt_n;
			ridx_q  <= ridx_n;
			armed_q <= armed_n;
		end
	end

	// route point for the next follow tick, from the state this clock leaves
	logic [IW-1:0] ridx_pf;
	logic          at_tgt_pf;
	logic [IW-1:0] ra_d;

	always_comb begin
		if (adv) begin
			ridx_pf   = ridx_n;
			at_tgt_pf = (x_now_n == x_tgt_n) && (y_now_n == y_tgt_n);
		end else begin
			ridx_pf   = ridx_q;
			at_tgt_pf = (x_now_q == x_tgt_q) && (y_now_q == y_tgt_q);
		end
	end

	pts_route #(.IW(IW)) u_route (
		.ridx      (ridx_pf),
		.len       (len_eff),
		.at_target (at_tgt_pf),
		.sel       (ra_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_q <= '0;
		end else begin
			ra_q <= ra_d;
		end
	end

	// out-of-range load indexes still disarm but write nothing
	assign ram_we    = adv && cmd_s1.action && (32'(pidx_s1) < ROUTE_DEPTH);
	assign ram_waddr = AW'(pidx_s1);
	assign ram_raddr = AW'(ra_d);
	assign ram_wdata = {PW'(py_s1), PW'(px_s1)};

	pts_ram #(.WIDTH(2 * PW), .DEPTH(ROUTE_DEPTH)) u_route_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else begin
			byp_hit_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= ram_wdata;
	end

	// result register
	logic [pts_pkg::M_TDATA_W-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {{pts_pkg::M_PAD_W{1'b0}},
				pts_pkg::RPT_W'(ridx_n),
				pts_pkg::FIELD_POS_W'(y_now_n),
				pts_pkg::FIELD_POS_W'(x_now_n)};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// a route load always leaves the route disarmed
	a_load_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1.action |=> !armed_q)
		else $error("route load did not clear armed flag");

	// only follow ticks move the route index
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !cmd_s1.action && (cmd_s1.direction != pts_pkg::DIR_FOLLOW)
		|=> $stable(ridx_q))
		else $error("route index changed on a non-follow transaction");

	// prefetched route point lies inside the route once the length has settled
	a_prefetch_range: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(wr_en) |-> (32'(ra_q) < 32'(len_eff)))
		else $error("prefetched route point beyond route length");

endmodule
